FILE: rtl/thermistor_table_interpolation_macros.svh
// Assertion macros shared by the thermistor table interpolation RTL.
`ifndef THERMISTOR_TABLE_INTERPOLATION_MACROS_SVH
`define THERMISTOR_TABLE_INTERPOLATION_MACROS_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define TTI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tti assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define TTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tti assertion failed");
`else
`define TTI_ASSERT_SAME(lbl, ante, cons)
`define TTI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/tti_pkg.sv
// Package: types and constants of the thermistor table interpolation block.
`default_nettype none
package tti_pkg;
	localparam int TABLE_ENTRIES_DEF = 23;
	localparam int ENTRY_W = 16;
	localparam int DIFF_W = ENTRY_W + 1;
	localparam int TEMP_W = 11;
	localparam int IDX_W = 6;
	localparam int Q_W = 6;
	localparam int REM_W = 22;
	localparam int BASE_TENTHS = -200;
	localparam int SEG_TENTHS = 50;
	localparam int CLAMP_HIGH_T = 900;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CONV = 1'b1;

	typedef enum logic [1:0] {
		ST_INTERP = 2'd0,
		ST_LOW    = 2'd1,
		ST_HIGH   = 2'd2,
		ST_NOSEG  = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   idx;
		logic [ENTRY_W-1:0] x;
		logic [ENTRY_W-1:0] d;
	} seg_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   idx;
		logic [ENTRY_W-1:0] d;
		logic [REM_W-1:0]   r;
		logic [Q_W-1:0]     q;
	} div_t;
endpackage
`default_nettype wire

FILE: rtl/tti_table.sv
// Calibration tables and the per-entry difference stage.
`default_nettype none
module tti_table import tti_pkg::*; #(
	parameter int N = TABLE_ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic                     wr_sel,
	input  wire logic [$clog2(N)-1:0]     wr_idx,
	input  wire logic signed [ENTRY_W-1:0] wr_value,
	input  wire logic                     en,
	input  wire logic                     sel,
	input  wire logic signed [ENTRY_W-1:0] raw,
	output logic signed [DIFF_W-1:0]      diff_s2 [N]
);
	logic signed [ENTRY_W-1:0] main_q [N];
	logic signed [ENTRY_W-1:0] sub_q [N];

	// Write one entry of the selected table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_sel) sub_q[wr_idx] <= wr_value;
			else main_q[wr_idx] <= wr_value;
		end
	end

	// Take entry minus reading for every entry
	for (genvar j = 0; j < N; j++) begin : g_diff
		logic signed [ENTRY_W-1:0] ent;
		assign ent = sel ? sub_q[j] : main_q[j];
		always_ff @(posedge clk) begin
			if (en) diff_s2[j] <= DIFF_W'(ent) - DIFF_W'(raw);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tti_seg.sv
// Segment search: clamp tests, matching segment and its span.
`default_nettype none
`include "thermistor_table_interpolation_macros.svh"
module tti_seg import tti_pkg::*; #(
	parameter int N = TABLE_ENTRIES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    vld_i,
	input  wire logic signed [DIFF_W-1:0] diff [N],
	output logic                         vld_s3,
	output seg_t                         seg_s3
);
	logic [N-1:0] ge;
	logic hit;
	logic [IDX_W-1:0] hit_idx;
	logic [DIFF_W-1:0] hi_d, lo_d, span;
	seg_t seg_c;

	// Mark entries at or above the reading
	always_comb begin
		for (int j = 0; j < N; j++) ge[j] = !diff[j][DIFF_W-1];
	end

	// Find the lowest matching segment
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		hi_d = '0;
		lo_d = '0;
		for (int j = N - 2; j >= 0; j--) begin
			if (ge[j] && !ge[j+1]) begin
				hit = 1'b1;
				hit_idx = IDX_W'(j);
				hi_d = diff[j];
				lo_d = diff[j+1];
			end
		end
		span = hi_d - lo_d;
		seg_c.idx = hit_idx;
		seg_c.x = hi_d[ENTRY_W-1:0];
		seg_c.d = span[ENTRY_W-1:0];
		priority if (!ge[0]) seg_c.status = ST_LOW;
		else if (ge[N-1]) seg_c.status = ST_HIGH;
		else if (hit) seg_c.status = ST_INTERP;
		else seg_c.status = ST_NOSEG;
	end

	// Advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_i;
	end
	always_ff @(posedge clk) begin
		if (en) seg_s3 <= seg_c;
	end

	`TTI_ASSERT_SAME(a_seg_span, vld_s3 && seg_s3.status == ST_INTERP, seg_s3.x < seg_s3.d)
endmodule
`default_nettype wire

FILE: rtl/tti_div_stage.sv
// One restoring divide step: resolves one quotient bit.
`default_nettype none
`include "thermistor_table_interpolation_macros.svh"
module tti_div_stage import tti_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic vld_i,
	input  wire div_t div_i,
	output logic      vld_q,
	output div_t      div_q
);
	logic [REM_W-1:0] dsh;
	div_t div_c;

	// Subtract the shifted divisor when it fits
	always_comb begin
		dsh = REM_W'(div_i.d) << SHIFT;
		div_c = div_i;
		if (div_i.r >= dsh) begin
			div_c.r = div_i.r - dsh;
			div_c.q[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_i;
	end
	always_ff @(posedge clk) begin
		if (en) div_q <= div_c;
	end

	`TTI_ASSERT_SAME(a_div_rem, vld_q && div_q.status == ST_INTERP,
		div_q.r < (REM_W'(div_q.d) << SHIFT))
endmodule
`default_nettype wire

FILE: rtl/thermistor_table_interpolation.sv
// Top level: thermistor table interpolation pipeline.
// Converts raw thermistor readings to tenths of a degree with two loadable
// 5-degree-step calibration tables. A load word writes one entry at once and
// gives no result; a convert word gives one result word after passing through
// every stage. One word is taken every cycle while the output is drained: the
// pipeline has the input stage, the entry-difference stage, the segment
// search, the scaling stage, six restoring divide steps and the output
// register, all advancing together on one stall. A load takes effect for
// every convert word accepted after it.
`default_nettype none
`include "thermistor_table_interpolation_macros.svh"
module thermistor_table_interpolation import tti_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// entry_index[4:0], entry_value[20:5], raw_reading[36:21], zero pad
	input  wire logic [39:0] s_axis_tdata,
	// command[0], table_select[1]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// temperature_tenths[10:0], zero pad
	output logic [15:0]      m_axis_tdata,
	// range_status[1:0]
	output logic [1:0]       m_axis_tuser
);
	localparam int TIW = $clog2(TABLE_ENTRIES);

	logic en, acc;
	logic [4:0] entry_index;
	logic signed [ENTRY_W-1:0] entry_value, raw_reading;
	logic vld_s1, sel_s1, vld_s2, vld_s3, vld_s4;
	logic signed [ENTRY_W-1:0] raw_s1;
	logic signed [DIFF_W-1:0] diff_s2 [TABLE_ENTRIES];
	seg_t seg_s3;
	div_t div_s4;
	logic vld_d [Q_W+1];
	div_t div_d [Q_W+1];
	logic [12:0] off;
	logic signed [13:0] vsum;
	logic signed [TEMP_W-1:0] temp_c;
	logic out_vld_q;
	logic signed [TEMP_W-1:0] temp_q;
	status_t status_q;

	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign entry_index = s_axis_tdata[4:0];
	assign entry_value = s_axis_tdata[20:5];
	assign raw_reading = s_axis_tdata[36:21];

	// Enter convert words into the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc && s_axis_tuser[0] == CMD_CONV;
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= s_axis_tuser[1];
			raw_s1 <= raw_reading;
		end
	end

	tti_table #(.N(TABLE_ENTRIES)) u_table (
		.clk      (clk),
		.wr_en    (acc && s_axis_tuser[0] == CMD_LOAD && 32'(entry_index) < TABLE_ENTRIES),
		.wr_sel   (s_axis_tuser[1]),
		.wr_idx   (TIW'(entry_index)),
		.wr_value (entry_value),
		.en       (en),
		.sel      (sel_s1),
		.raw      (raw_s1),
		.diff_s2  (diff_s2)
	);

	tti_seg #(.N(TABLE_ENTRIES)) u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s2),
		.diff   (diff_s2),
		.vld_s3 (vld_s3),
		.seg_s3 (seg_s3)
	);

	// Scale the offset by fifty to get the tenths numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			div_s4.status <= seg_s3.status;
			div_s4.idx <= seg_s3.idx;
			div_s4.d <= seg_s3.d;
			div_s4.r <= (REM_W'(seg_s3.x) << 5) + (REM_W'(seg_s3.x) << 4)
				+ (REM_W'(seg_s3.x) << 1);
			div_s4.q <= '0;
		end
	end

	assign vld_d[0] = vld_s4;
	assign div_d[0] = div_s4;
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		tti_div_stage #(.SHIFT(Q_W - 1 - k)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld_d[k]),
			.div_i  (div_d[k]),
			.vld_q  (vld_d[k+1]),
			.div_q  (div_d[k+1])
		);
	end

	// Form the temperature and apply the status overrides
	always_comb begin
		off = 13'(div_d[Q_W].idx) * 13'(SEG_TENTHS) + 13'(div_d[Q_W].q);
		vsum = $signed({1'b0, off}) + 14'(BASE_TENTHS);
		unique case (div_d[Q_W].status)
			ST_INTERP: temp_c = (vsum > 14'(CLAMP_HIGH_T)) ? TEMP_W'(CLAMP_HIGH_T)
				: TEMP_W'(vsum);
			ST_LOW:    temp_c = TEMP_W'(BASE_TENTHS);
			ST_HIGH:   temp_c = TEMP_W'(CLAMP_HIGH_T);
			default:   temp_c = '0;
		endcase
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_d[Q_W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			temp_q <= temp_c;
			status_q <= div_d[Q_W].status;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {{(16 - TEMP_W){1'b0}}, temp_q};
	assign m_axis_tuser = status_q;

	`TTI_ASSERT_NEXT(a_stall_holds_s4, !en, vld_s4 == $past(vld_s4))
	`TTI_ASSERT_NEXT(a_load_no_entry, en && !(acc && s_axis_tuser[0] == CMD_CONV), !vld_s1)
endmodule
`default_nettype wire
